### hw/rtl/jts_pkg.sv
// jts_pkg: shared types, codes and character helpers of the json token scanner
// used by jts_scan_core, jts_result_fifo, json_token_scanner_top and jts_checker
// no dependencies

package jts_pkg;

    // scanner modes, codes 12 to 15 are never entered and behave like the error mode
    typedef enum logic [3:0] {
        MODE_IDLE   = 4'd0,
        MODE_STR    = 4'd1,
        MODE_ESC    = 4'd2,
        MODE_NSIGN  = 4'd3,
        MODE_NINT   = 4'd4,
        MODE_NDOT   = 4'd5,
        MODE_NFRAC  = 4'd6,
        MODE_NE     = 4'd7,
        MODE_NESIGN = 4'd8,
        MODE_NEXP   = 4'd9,
        MODE_KW     = 4'd10,
        MODE_ERR    = 4'd11
    } mode_t;

    localparam logic [3:0] KIND_LBRACK  = 4'd0;
    localparam logic [3:0] KIND_RBRACK  = 4'd1;
    localparam logic [3:0] KIND_LBRACE  = 4'd2;
    localparam logic [3:0] KIND_RBRACE  = 4'd3;
    localparam logic [3:0] KIND_COMMA   = 4'd4;
    localparam logic [3:0] KIND_COLON   = 4'd5;
    localparam logic [3:0] KIND_TRUE    = 4'd6;
    localparam logic [3:0] KIND_STRING  = 4'd9;
    localparam logic [3:0] KIND_INTEGER = 4'd10;
    localparam logic [3:0] KIND_REAL    = 4'd11;
    localparam logic [3:0] KIND_END     = 4'd12;
    localparam logic [3:0] KIND_ERROR   = 4'd13;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_STR_CHAR   = 3'd1;
    localparam logic [2:0] ERR_ESCAPE     = 3'd2;
    localparam logic [2:0] ERR_DIGIT      = 3'd3;
    localparam logic [2:0] ERR_UNKNOWN    = 3'd4;

    localparam logic [1:0] KW_TRUE  = 2'd0;
    localparam logic [1:0] KW_FALSE = 2'd1;
    localparam logic [1:0] KW_NULL  = 2'd2;

    // result queue between the scanner and the output port
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic       is_token;
        logic [3:0] token_kind;
        logic [2:0] error_code;
        logic [7:0] payload_char;
        logic       last;
    } result_t;

    // results of one scanned transaction, in order
    typedef struct packed {
        result_t    res0;
        result_t    res1;
        logic [1:0] count;
    } scan_out_t;

    typedef struct packed {
        mode_t      mode;
        logic       res_v;
        result_t    res;
        logic       kw_start;
        logic [1:0] kw_id;
    } idle_step_t;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= "0") && (b <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == " ") || ((b >= 8'd9) && (b <= 8'd13));
    endfunction

    function automatic result_t mk_token(input logic [3:0] kind);
        result_t r;
        r = '0;
        r.is_token   = 1'b1;
        r.token_kind = kind;
        return r;
    endfunction

    function automatic result_t mk_error(input logic [2:0] code);
        result_t r;
        r = '0;
        r.is_token   = 1'b1;
        r.token_kind = KIND_ERROR;
        r.error_code = code;
        return r;
    endfunction

    function automatic result_t mk_payload(input logic [7:0] ch);
        result_t r;
        r = '0;
        r.payload_char = ch;
        return r;
    endfunction

    // bit 8 set means the escape is not recognized
    function automatic logic [8:0] unescape(input logic [7:0] b);
        logic [8:0] d;
        case (b)
            "\"":    d = {1'b0, 8'h22};
            "\\":    d = {1'b0, 8'h5C};
            "/":     d = {1'b0, 8'h2F};
            "b":     d = {1'b0, 8'd8};
            "f":     d = {1'b0, 8'd12};
            "n":     d = {1'b0, 8'd10};
            "r":     d = {1'b0, 8'd13};
            "t":     d = {1'b0, 8'd9};
            default: d = {1'b1, 8'd0};
        endcase
        return d;
    endfunction

    function automatic logic [2:0] kw_len(input logic [1:0] id);
        logic [2:0] n;
        case (id)
            KW_TRUE:  n = 3'd4;
            KW_FALSE: n = 3'd5;
            KW_NULL:  n = 3'd4;
            default:  n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] kw_char(input logic [1:0] id, input logic [2:0] pos);
        logic [39:0] text;
        logic [7:0]  c;
        case (id)
            KW_TRUE:  text = {8'd0, "eurt"};
            KW_FALSE: text = "eslaf";
            KW_NULL:  text = {8'd0, "llun"};
            default:  text = '0;
        endcase
        case (pos)
            3'd0:    c = text[7:0];
            3'd1:    c = text[15:8];
            3'd2:    c = text[23:16];
            3'd3:    c = text[31:24];
            3'd4:    c = text[39:32];
            default: c = 8'd0;
        endcase
        return c;
    endfunction

    // a byte seen between tokens
    function automatic idle_step_t scan_idle(input logic [7:0] b);
        idle_step_t s;
        s = '0;
        s.mode = MODE_IDLE;
        if (!is_space(b)) begin
            s.res_v = 1'b1;
            case (b)
                "[": s.res = mk_token(KIND_LBRACK);
                "]": s.res = mk_token(KIND_RBRACK);
                "{": s.res = mk_token(KIND_LBRACE);
                "}": s.res = mk_token(KIND_RBRACE);
                ",": s.res = mk_token(KIND_COMMA);
                ":": s.res = mk_token(KIND_COLON);
                "\"": begin
                    s.res_v = 1'b0;
                    s.mode  = MODE_STR;
                end
                "t", "f", "n": begin
                    s.res_v    = 1'b0;
                    s.mode     = MODE_KW;
                    s.kw_start = 1'b1;
                    s.kw_id    = (b == "t") ? KW_TRUE : ((b == "f") ? KW_FALSE : KW_NULL);
                end
                "-", "+": begin
                    s.mode = MODE_NSIGN;
                    s.res  = mk_payload(b);
                end
                default: begin
                    if (is_digit(b)) begin
                        s.mode = MODE_NINT;
                        s.res  = mk_payload(b);
                    end else begin
                        s.mode = MODE_ERR;
                        s.res  = mk_error(ERR_UNKNOWN);
                    end
                end
            endcase
        end
        return s;
    endfunction

endpackage

### hw/rtl/jts_scan_core.sv
// jts_scan_core: scanner state registers and the combinational next-state and result logic
// depends on jts_pkg

module jts_scan_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  logic [7:0]        in_byte,
    input  logic              end_of_input,
    output jts_pkg::scan_out_t scan_out
);

    jts_pkg::mode_t mode_reg, mode_next;
    logic [1:0] kw_id_reg, kw_id_next;
    logic [2:0] kw_pos_reg, kw_pos_next;
    logic       kw_bad_reg, kw_bad_next;

    logic                 pre_v;
    jts_pkg::result_t     pre_r;
    logic                 sec_v;
    jts_pkg::result_t     sec_r;
    logic                 go_idle;
    logic                 kw_ok;
    logic [8:0]           esc;
    jts_pkg::idle_step_t  idle_s;

    assign idle_s = jts_pkg::scan_idle(in_byte);
    assign esc    = jts_pkg::unescape(in_byte);
    assign kw_ok  = (kw_id_reg != 2'd3) && !kw_bad_reg
                    && (kw_pos_reg == jts_pkg::kw_len(kw_id_reg));

    always_comb begin
        mode_next   = mode_reg;
        kw_id_next  = kw_id_reg;
        kw_pos_next = kw_pos_reg;
        kw_bad_next = kw_bad_reg;
        pre_v       = 1'b0;
        pre_r       = '0;
        sec_v       = 1'b0;
        sec_r       = '0;
        go_idle     = 1'b0;
        if (end_of_input) begin
            case (mode_reg)
                jts_pkg::MODE_STR: begin
                    pre_v = 1'b1;
                    pre_r = jts_pkg::mk_error(jts_pkg::ERR_STR_CHAR);
                end
                jts_pkg::MODE_ESC: begin
                    pre_v = 1'b1;
                    pre_r = jts_pkg::mk_error(jts_pkg::ERR_ESCAPE);
                end
                jts_pkg::MODE_NSIGN, jts_pkg::MODE_NDOT, jts_pkg::MODE_NESIGN: begin
                    pre_v = 1'b1;
                    pre_r = jts_pkg::mk_error(jts_pkg::ERR_DIGIT);
                end
                jts_pkg::MODE_NINT: begin
                    pre_v = 1'b1;
                    pre_r = jts_pkg::mk_token(jts_pkg::KIND_INTEGER);
                end
                jts_pkg::MODE_NFRAC, jts_pkg::MODE_NE, jts_pkg::MODE_NEXP: begin
                    pre_v = 1'b1;
                    pre_r = jts_pkg::mk_token(jts_pkg::KIND_REAL);
                end
                jts_pkg::MODE_KW: begin
                    pre_v = 1'b1;
                    pre_r = kw_ok ? jts_pkg::mk_token(jts_pkg::KIND_TRUE + {2'b00, kw_id_reg})
                                  : jts_pkg::mk_error(jts_pkg::ERR_UNKNOWN);
                end
                default: begin
                    pre_v = 1'b0;
                end
            endcase
            sec_v       = 1'b1;
            sec_r       = jts_pkg::mk_token(jts_pkg::KIND_END);
            mode_next   = jts_pkg::MODE_IDLE;
            kw_id_next  = 2'd0;
            kw_pos_next = 3'd0;
            kw_bad_next = 1'b0;
        end else begin
            case (mode_reg)
                jts_pkg::MODE_IDLE: begin
                    go_idle = 1'b1;
                end
                jts_pkg::MODE_STR: begin
                    pre_v = 1'b1;
                    if (in_byte == "\"") begin
                        mode_next = jts_pkg::MODE_IDLE;
                        pre_r     = jts_pkg::mk_token(jts_pkg::KIND_STRING);
                    end else if (in_byte == "\\") begin
                        pre_v     = 1'b0;
                        mode_next = jts_pkg::MODE_ESC;
                    end else if (in_byte == 8'd10 || in_byte == 8'd13 || in_byte == 8'd0) begin
                        mode_next = jts_pkg::MODE_ERR;
                        pre_r     = jts_pkg::mk_error(jts_pkg::ERR_STR_CHAR);
                    end else begin
                        pre_r = jts_pkg::mk_payload(in_byte);
                    end
                end
                jts_pkg::MODE_ESC: begin
                    pre_v = 1'b1;
                    if (esc[8]) begin
                        mode_next = jts_pkg::MODE_ERR;
                        pre_r     = jts_pkg::mk_error(jts_pkg::ERR_ESCAPE);
                    end else begin
                        mode_next = jts_pkg::MODE_STR;
                        pre_r     = jts_pkg::mk_payload(esc[7:0]);
                    end
                end
                jts_pkg::MODE_NSIGN, jts_pkg::MODE_NDOT, jts_pkg::MODE_NESIGN: begin
                    pre_v = 1'b1;
                    if (!jts_pkg::is_digit(in_byte)) begin
                        mode_next = jts_pkg::MODE_ERR;
                        pre_r     = jts_pkg::mk_error(jts_pkg::ERR_DIGIT);
                    end else begin
                        pre_r = jts_pkg::mk_payload(in_byte);
                        if (mode_reg == jts_pkg::MODE_NSIGN) begin
                            mode_next = jts_pkg::MODE_NINT;
                        end else if (mode_reg == jts_pkg::MODE_NDOT) begin
                            mode_next = jts_pkg::MODE_NFRAC;
                        end else begin
                            mode_next = jts_pkg::MODE_NEXP;
                        end
                    end
                end
                jts_pkg::MODE_NINT, jts_pkg::MODE_NFRAC: begin
                    pre_v = 1'b1;
                    if (jts_pkg::is_digit(in_byte)) begin
                        pre_r = jts_pkg::mk_payload(in_byte);
                    end else if (in_byte == "." && mode_reg == jts_pkg::MODE_NINT) begin
                        mode_next = jts_pkg::MODE_NDOT;
                        pre_r     = jts_pkg::mk_payload(in_byte);
                    end else if (in_byte == "e" || in_byte == "E") begin
                        mode_next = jts_pkg::MODE_NE;
                        pre_r     = jts_pkg::mk_payload(in_byte);
                    end else begin
                        // number ends here, the byte starts the next token
                        go_idle = 1'b1;
                        pre_r   = jts_pkg::mk_token((mode_reg == jts_pkg::MODE_NINT)
                                                    ? jts_pkg::KIND_INTEGER
                                                    : jts_pkg::KIND_REAL);
                    end
                end
                jts_pkg::MODE_NE: begin
                    pre_v = 1'b1;
                    if (in_byte == "+" || in_byte == "-") begin
                        mode_next = jts_pkg::MODE_NESIGN;
                        pre_r     = jts_pkg::mk_payload(in_byte);
                    end else if (jts_pkg::is_digit(in_byte)) begin
                        mode_next = jts_pkg::MODE_NEXP;
                        pre_r     = jts_pkg::mk_payload(in_byte);
                    end else begin
                        go_idle = 1'b1;
                        pre_r   = jts_pkg::mk_token(jts_pkg::KIND_REAL);
                    end
                end
                jts_pkg::MODE_NEXP: begin
                    pre_v = 1'b1;
                    if (jts_pkg::is_digit(in_byte)) begin
                        pre_r = jts_pkg::mk_payload(in_byte);
                    end else begin
                        go_idle = 1'b1;
                        pre_r   = jts_pkg::mk_token(jts_pkg::KIND_REAL);
                    end
                end
                jts_pkg::MODE_KW: begin
                    if (jts_pkg::is_alpha(in_byte)) begin
                        if (!kw_bad_reg) begin
                            if (kw_id_reg != 2'd3
                                && kw_pos_reg < jts_pkg::kw_len(kw_id_reg)
                                && jts_pkg::kw_char(kw_id_reg, kw_pos_reg) == in_byte) begin
                                kw_pos_next = kw_pos_reg + 3'd1;
                            end else begin
                                kw_bad_next = 1'b1;
                            end
                        end
                    end else begin
                        pre_v = 1'b1;
                        if (kw_ok) begin
                            go_idle = 1'b1;
                            pre_r   = jts_pkg::mk_token(jts_pkg::KIND_TRUE + {2'b00, kw_id_reg});
                        end else begin
                            mode_next = jts_pkg::MODE_ERR;
                            pre_r     = jts_pkg::mk_error(jts_pkg::ERR_UNKNOWN);
                        end
                    end
                end
                default: begin
                    pre_v = 1'b0;
                end
            endcase
            if (go_idle) begin
                mode_next = idle_s.mode;
                sec_v     = idle_s.res_v;
                sec_r     = idle_s.res;
                if (idle_s.kw_start) begin
                    kw_id_next  = idle_s.kw_id;
                    kw_pos_next = 3'd1;
                    kw_bad_next = 1'b0;
                end
            end
        end
    end

    // pack the results in order and mark the final one
    always_comb begin
        scan_out       = '0;
        scan_out.count = {1'b0, pre_v} + {1'b0, sec_v};
        scan_out.res0  = pre_v ? pre_r : sec_r;
        scan_out.res1  = sec_r;
        if (pre_v && sec_v) begin
            scan_out.res1.last = 1'b1;
        end else begin
            scan_out.res0.last = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= jts_pkg::MODE_IDLE;
            kw_id_reg  <= 2'd0;
            kw_pos_reg <= 3'd0;
            kw_bad_reg <= 1'b0;
        end else if (fire) begin
            mode_reg   <= mode_next;
            kw_id_reg  <= kw_id_next;
            kw_pos_reg <= kw_pos_next;
            kw_bad_reg <= kw_bad_next;
        end
    end

endmodule

### hw/rtl/jts_result_fifo.sv
// jts_result_fifo: small result queue, up to two writes and one read per cycle
// depends on jts_pkg

module jts_result_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  jts_pkg::scan_out_t wr_data,
    output logic               has_room,
    output logic               rd_valid,
    input  logic               rd_ready,
    output jts_pkg::result_t   rd_data
);

    localparam int AW = jts_pkg::FIFO_AW;

    jts_pkg::result_t entry_reg [jts_pkg::FIFO_DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   count_reg, count_next;
    logic [1:0]    n_push;
    logic          pop;

    assign n_push   = push ? wr_data.count : 2'd0;
    assign pop      = rd_valid && rd_ready;
    assign rd_valid = (count_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    // room for the two results one transaction can give
    assign has_room = (count_reg <= (AW+1)'(jts_pkg::FIFO_DEPTH - 2));

    always_comb begin
        wr_ptr_next = wr_ptr_reg + AW'(n_push);
        rd_ptr_next = rd_ptr_reg + AW'(pop);
        count_next  = count_reg + (AW+1)'(n_push) - (AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (n_push != 2'd0) begin
            entry_reg[wr_ptr_reg] <= wr_data.res0;
        end
        if (n_push == 2'd2) begin
            entry_reg[wr_ptr_reg + AW'(1)] <= wr_data.res1;
        end
    end

endmodule

### hw/rtl/json_token_scanner_top.sv
// json_token_scanner_top: streaming json lexer, one text byte per transaction
// depends on jts_pkg, jts_scan_core and jts_result_fifo
//
//   channel | direction | handshake        | fields
//   s_      | in        | s_valid/s_ready  | in_byte, end_of_input
//   m_      | out       | m_valid/m_ready  | is_token, token_kind, error_code,
//           |           |                  | payload_char, last
//
// one input transaction is taken per cycle while s_ready is high; its zero, one or two results are
// computed in the same cycle and written into a four-entry result queue
// the output gives one result per cycle from the queue head while m_ready is high, so the sustained
// rate is one byte per cycle as long as bytes give at most one result each
// s_ready is low while the queue has fewer than two free entries
// reset returns the scanner to idle and empties the queue

module json_token_scanner_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_end_of_input,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_is_token,
    output logic [3:0] m_token_kind,
    output logic [2:0] m_error_code,
    output logic [7:0] m_payload_char,
    output logic       m_last
);

    logic               fire;
    jts_pkg::scan_out_t scan_out;
    jts_pkg::result_t   head;

    assign fire = s_valid && s_ready;

    jts_scan_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fire         (fire),
        .in_byte      (s_in_byte),
        .end_of_input (s_end_of_input),
        .scan_out     (scan_out)
    );

    jts_result_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (fire),
        .wr_data  (scan_out),
        .has_room (s_ready),
        .rd_valid (m_valid),
        .rd_ready (m_ready),
        .rd_data  (head)
    );

    assign m_is_token     = head.is_token;
    assign m_token_kind   = head.token_kind;
    assign m_error_code   = head.error_code;
    assign m_payload_char = head.payload_char;
    assign m_last         = head.last;

endmodule

### hw/rtl/jts_checker.sv
// jts_checker: port-level checks of json_token_scanner_top, attached by bind
// depends on jts_pkg

module jts_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_is_token,
    input logic [3:0] m_token_kind,
    input logic [2:0] m_error_code,
    input logic [7:0] m_payload_char,
    input logic       m_last
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_is_token) && $stable(m_token_kind)
            && $stable(m_error_code) && $stable(m_payload_char) && $stable(m_last))
        else $error("result changed while stalled");

    // payload characters carry no kind and no error code
    a_payload_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_is_token |-> m_token_kind == jts_pkg::KIND_LBRACK
            && m_error_code == jts_pkg::ERR_NONE)
        else $error("payload result with kind or error set");

    // error code only with an error token, and only then nonzero
    a_error_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_token |->
            ((m_token_kind == jts_pkg::KIND_ERROR) == (m_error_code != jts_pkg::ERR_NONE)))
        else $error("error code does not match token kind");

    // the end token carries no character and closes its transaction
    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_token && m_token_kind == jts_pkg::KIND_END |-> m_last
            && m_payload_char == 8'd0)
        else $error("end token not marked last");

    // a kind beyond the error token never appears
    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_token_kind <= jts_pkg::KIND_ERROR)
        else $error("token kind out of range");

endmodule

bind json_token_scanner_top jts_checker u_jts_checker (.*);
